>>> hdl/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg: shared types and codes for the nearest palette color core
// Item kind codes, fixed field widths and the control word passed cell to cell.
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam int SLOT_W = 4;  // entry_index field
  localparam int OUT_W  = 4;  // nearest_index field

  // Control word that travels down the cell chain with each item
  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [OUT_W-1:0]  best_idx;
  } npc_ctrl_t;

endpackage

>>> hdl/npc_cell.sv
// ----------------------------------------------------------------------------
// npc_cell: one palette slot of the search chain
// Holds one palette entry, takes loads aimed at it, and for queries folds its
// own squared distance into the running best. Two register stages per cell.
// ----------------------------------------------------------------------------
module npc_cell #(
  parameter int COMPONENT_BITS = 8,
  parameter int CELL_ID        = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  npc_pkg::npc_ctrl_t          ctrl_i,
  input  logic [3*COMPONENT_BITS-1:0] color_i,
  input  logic [2*COMPONENT_BITS+1:0] dist_i,
  output npc_pkg::npc_ctrl_t          ctrl_o,
  output logic [3*COMPONENT_BITS-1:0] color_o,
  output logic [2*COMPONENT_BITS+1:0] dist_o
);

  localparam int CB = COMPONENT_BITS;
  localparam int SW = 2 * CB;
  localparam int DW = 2 * CB + 2;
  localparam logic [31:0] ID_VEC = CELL_ID;
  localparam bit ID_FITS = (CELL_ID < (2 ** npc_pkg::SLOT_W));

  logic [3*CB-1:0]    entry_r;
  logic [3*CB-1:0]    entry_nxt;
  npc_pkg::npc_ctrl_t ctrl_a_r;
  logic [3*CB-1:0]    color_a_r;
  logic [DW-1:0]      dist_a_r;
  logic [SW-1:0]      sq_r [3];
  logic [SW-1:0]      sq_nxt [3];
  npc_pkg::npc_ctrl_t ctrl_b_r;
  npc_pkg::npc_ctrl_t ctrl_b_nxt;
  logic [3*CB-1:0]    color_b_r;
  logic [DW-1:0]      dist_b_r;
  logic [DW-1:0]      dist_b_nxt;
  logic [DW-1:0]      sum;
  logic               hit;

  assign hit = ID_FITS && (ctrl_i.slot == ID_VEC[npc_pkg::SLOT_W-1:0]);

  always_comb begin
    entry_nxt = entry_r;
    if (adv && ctrl_i.valid && (ctrl_i.kind == npc_pkg::KIND_LOAD) && hit) begin
      entry_nxt = color_i;
    end
  end

  // Squared component differences against the stored entry
  always_comb begin
    logic [CB-1:0] a;
    logic [CB-1:0] b;
    logic [CB-1:0] d;
    for (int k = 0; k < 3; k++) begin
      a = entry_r[k*CB +: CB];
      b = color_i[k*CB +: CB];
      d = (a >= b) ? (a - b) : (b - a);
      sq_nxt[k] = SW'(d) * SW'(d);
    end
  end

  assign sum = DW'(sq_r[0]) + DW'(sq_r[1]) + DW'(sq_r[2]);

  // Take the entry only when strictly closer: ties keep the lower index
  always_comb begin
    ctrl_b_nxt = ctrl_a_r;
    dist_b_nxt = dist_a_r;
    if (ctrl_a_r.valid && (ctrl_a_r.kind == npc_pkg::KIND_QUERY) && (sum < dist_a_r)) begin
      dist_b_nxt          = sum;
      ctrl_b_nxt.best_idx = ID_VEC[npc_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r  <= '0;
      ctrl_a_r <= '0;
      ctrl_b_r <= '0;
    end else begin
      entry_r <= entry_nxt;
      if (adv) begin
        ctrl_a_r <= ctrl_i;
        ctrl_b_r <= ctrl_b_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      color_a_r <= color_i;
      dist_a_r  <= dist_i;
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= sq_nxt[k];
      end
      color_b_r <= color_a_r;
      dist_b_r  <= dist_b_nxt;
    end
  end

  assign ctrl_o  = ctrl_b_r;
  assign color_o = color_b_r;
  assign dist_o  = dist_b_r;

endmodule

>>> hdl/nearest_palette_color_core.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_core: nearest palette entry by squared RGB distance
// Top level: stream ports, the chain of palette cells and the result register.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while the chain is not stalled. Each item,
// load or query, walks a chain of PALETTE_ENTRIES cells, two register stages per
// cell, and a query result then lands in the output register. Loads travel the
// same chain so items always see the palette in arrival order. A load writes the
// slot named by entry_index (slots not below PALETTE_ENTRIES are ignored) and
// gives no result. A query returns the index of the nearest entry, lowest on a
// tie, counting only distances strictly below 3*(2^COMPONENT_BITS-1)^2, or 0 if
// none is. The palette resets to black.
// The chain stalls as a whole only while a query result waits on out_tready.
module nearest_palette_color_core #(
  parameter int PALETTE_ENTRIES = 16,
  parameter int COMPONENT_BITS  = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [((npc_pkg::SLOT_W + 3 * COMPONENT_BITS + 7) / 8) * 8 - 1:0]
                       in_tdata,      // entry_index, red, green, blue
  input  logic         in_tuser,      // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata      // nearest_index
);

  localparam int CB   = COMPONENT_BITS;
  localparam int DW   = 2 * CB + 2;
  localparam logic [63:0] CMAX = (64'd1 << CB) - 64'd1;
  localparam logic [DW-1:0] DIST_LIMIT = DW'(64'd3 * CMAX * CMAX);

  npc_pkg::npc_ctrl_t   ctrl_w  [PALETTE_ENTRIES+1];
  logic [3*CB-1:0]      color_w [PALETTE_ENTRIES+1];
  logic [DW-1:0]        dist_w  [PALETTE_ENTRIES+1];

  logic                     adv;
  logic                     emit;
  logic                     out_tvalid_r;
  logic                     out_tvalid_nxt;
  logic [npc_pkg::OUT_W-1:0] out_idx_r;

  assign ctrl_w[0].valid    = in_tvalid;
  assign ctrl_w[0].kind     = in_tuser;
  assign ctrl_w[0].slot     = in_tdata[npc_pkg::SLOT_W-1:0];
  assign ctrl_w[0].best_idx = '0;
  assign color_w[0]         = in_tdata[npc_pkg::SLOT_W +: 3*CB];
  assign dist_w[0]          = DIST_LIMIT;

  for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
    npc_cell #(
      .COMPONENT_BITS(CB),
      .CELL_ID       (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .ctrl_i (ctrl_w[i]),
      .color_i(color_w[i]),
      .dist_i (dist_w[i]),
      .ctrl_o (ctrl_w[i+1]),
      .color_o(color_w[i+1]),
      .dist_o (dist_w[i+1])
    );
  end

  assign emit = ctrl_w[PALETTE_ENTRIES].valid
             && (ctrl_w[PALETTE_ENTRIES].kind == npc_pkg::KIND_QUERY);
  // Hold the chain only when a finished query has nowhere to go
  assign adv  = !out_tvalid_r || out_tready || !emit;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (adv && emit) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_idx_r <= ctrl_w[PALETTE_ENTRIES].best_idx;
    end
  end

  assign in_tready  = adv;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = 8'(out_idx_r);

  a_reset_clears_chain : assert property (@(posedge clk)
    !rst_n |=> !ctrl_w[PALETTE_ENTRIES].valid)
    else $error("chain end valid right after reset");

  a_dist_in_limit : assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_w[PALETTE_ENTRIES].valid |-> (dist_w[PALETTE_ENTRIES] <= DIST_LIMIT))
    else $error("best distance above limit");

  a_stall_holds_end : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(ctrl_w[PALETTE_ENTRIES]) && $stable(dist_w[PALETTE_ENTRIES]))
    else $error("chain moved during stall");

  a_load_no_result : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tready && !emit) |=> !out_tvalid_r)
    else $error("result produced without a query");

  a_idx_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (32'(ctrl_w[PALETTE_ENTRIES].best_idx) < PALETTE_ENTRIES))
    else $error("best index outside palette");

endmodule

>>> test/nearest_palette_color_core_tb.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_core_tb: self-checking bench for the nearest palette core
// Streams palette loads and color queries through the core with random gaps and
// back-pressure, predicts each nearest index from a shadow palette, and checks
// every result in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_palette_color_core_tb;

  localparam int PALETTE_ENTRIES = 16;
  localparam int COMPONENT_BITS  = 8;
  localparam int unsigned DIST_LIMIT = 3 * 255 * 255;
  localparam int CHAIN_LATENCY   = 2 * PALETTE_ENTRIES + 1;
  localparam int RANDOM_ITEMS    = 350;
  localparam int LONG_HOLD       = 250;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Shadow palette plus the queue of nearest indices still owed by the core
  class nearest_color_predictor;
    bit [7:0] pal_red   [PALETTE_ENTRIES];
    bit [7:0] pal_green [PALETTE_ENTRIES];
    bit [7:0] pal_blue  [PALETTE_ENTRIES];
    bit [3:0] owed_index[$];
    int       fault_count;

    function int unsigned sq_diff(bit [7:0] a, bit [7:0] b);
      int unsigned d;
      d = (a >= b) ? a - b : b - a;
      return d * d;
    endfunction

    function void note_item(logic kind, bit [3:0] slot, bit [7:0] r, bit [7:0] g,
                            bit [7:0] b);
      int unsigned best_dist;
      int unsigned d;
      bit [3:0]    best_idx;
      if (kind == npc_pkg::KIND_LOAD) begin
        pal_red[slot]   = r;
        pal_green[slot] = g;
        pal_blue[slot]  = b;
        return;
      end
      best_dist = DIST_LIMIT;
      best_idx  = '0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
        d = sq_diff(pal_red[i], r) + sq_diff(pal_green[i], g) + sq_diff(pal_blue[i], b);
        // strict compare keeps the lower index on a tie
        if (d < best_dist) begin
          best_dist = d;
          best_idx  = i[3:0];
        end
      end
      owed_index.push_back(best_idx);
    endfunction

    function void check_index(logic [7:0] tdata);
      bit [3:0] want;
      if (owed_index.size() == 0) begin
        if (fault_count < 10)
          $display("ERROR: result %0d arrived with no query pending", tdata[3:0]);
        fault_count++;
        return;
      end
      want = owed_index.pop_front();
      if (tdata[3:0] !== want) begin
        if (fault_count < 10)
          $display("ERROR: nearest_index expected %0d, got %0d", want, tdata[3:0]);
        fault_count++;
      end
    endfunction

    function int pending();
      return owed_index.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;  // entry_index, red, green, blue
  logic        in_tuser   = 1'b0; // kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // nearest_index

  nearest_color_predictor pred = new;
  bit steady;        // no random gaps on either side while set
  bit hold_request;  // ask the receiver for one long hold-off

  nearest_palette_color_core #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .COMPONENT_BITS (COMPONENT_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function bit [7:0] nudge(bit [7:0] v);
    int t;
    t = int'(v) + $urandom_range(0, 6) - 3;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

  task automatic send_item(logic kind, bit [3:0] slot, bit [7:0] r, bit [7:0] g,
                           bit [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0000, b, g, r, slot};
    do @(posedge clk); while (in_tready !== 1'b1);
    pred.note_item(kind, slot, r, g, b);
  endtask

  // Drop valid and hold until the core owes nothing
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pred.pending() != 0) @(posedge clk);
  endtask

  task automatic random_item();
    logic     kind;
    bit [3:0] slot;
    bit [3:0] k;
    bit [7:0] c[3];
    int       mode;
    bit [7:0] picks[6];
    picks = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    kind = ($urandom_range(0, 99) < 30) ? npc_pkg::KIND_LOAD : npc_pkg::KIND_QUERY;
    slot = 4'($urandom_range(0, 15));
    k    = 4'($urandom_range(0, 15));
    mode = $urandom_range(0, 9);
    for (int j = 0; j < 3; j++) begin
      case (mode)
        5:       c[j] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        6, 7:    c[j] = nudge(j == 0 ? pred.pal_red[k] : j == 1 ? pred.pal_green[k]
                                                              : pred.pal_blue[k]);
        8:       c[j] = j == 0 ? pred.pal_red[k] : j == 1 ? pred.pal_green[k]
                                                          : pred.pal_blue[k];
        9:       c[j] = picks[$urandom_range(0, 5)];
        default: c[j] = 8'($urandom_range(0, 255));
      endcase
    end
    send_item(kind, slot, c[0], c[1], c[2]);
  endtask

  // Load every slot with one color, then query with a chosen color
  task automatic fill_and_query(bit [7:0] fr, bit [7:0] fg, bit [7:0] fb,
                                bit [7:0] qr, bit [7:0] qg, bit [7:0] qb);
    for (int s = 0; s < PALETTE_ENTRIES; s++)
      send_item(npc_pkg::KIND_LOAD, s[3:0], fr, fg, fb);
    send_item(npc_pkg::KIND_QUERY, 4'($urandom_range(0, 15)), qr, qg, qb);
  endtask

  // Receiver: check results and throttle out_tready
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready === 1'b1)
        pred.check_index(out_tdata);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = LONG_HOLD;
      end else if (stall > 0) begin
        stall--;
      end else if (rst_n) begin
        stall = pick_gap();
      end
      out_tready <= (stall == 0) && rst_n;
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("nearest_palette_color_core test failed");
    $finish;
  end

  initial begin
    steady = 1'b0;
    hold_request = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // palette is all black after reset: white sits exactly at the limit
    send_item(npc_pkg::KIND_QUERY, 4'd15, 8'd255, 8'd255, 8'd255);
    send_item(npc_pkg::KIND_QUERY, 4'd0, 8'd0, 8'd0, 8'd0);
    send_item(npc_pkg::KIND_LOAD, 4'd15, 8'd255, 8'd255, 8'd255);
    send_item(npc_pkg::KIND_QUERY, 4'd0, 8'd255, 8'd255, 8'd255);
    // equal entries: the lower slot wins
    send_item(npc_pkg::KIND_LOAD, 4'd9, 8'd10, 8'd20, 8'd30);
    send_item(npc_pkg::KIND_LOAD, 4'd3, 8'd10, 8'd20, 8'd30);
    send_item(npc_pkg::KIND_QUERY, 4'd9, 8'd10, 8'd20, 8'd31);
    send_item(npc_pkg::KIND_LOAD, 4'd0, 8'd255, 8'd0, 8'd0);
    send_item(npc_pkg::KIND_LOAD, 4'd1, 8'd0, 8'd255, 8'd0);
    send_item(npc_pkg::KIND_LOAD, 4'd2, 8'd0, 8'd0, 8'd255);
    send_item(npc_pkg::KIND_QUERY, 4'd5, 8'd250, 8'd5, 8'd5);
    send_item(npc_pkg::KIND_QUERY, 4'd10, 8'd0, 8'd255, 8'd1);
    send_item(npc_pkg::KIND_QUERY, 4'd15, 8'd0, 8'd0, 8'd255);
    send_item(npc_pkg::KIND_QUERY, 4'd3, 8'd128, 8'd128, 8'd128);
    send_item(npc_pkg::KIND_QUERY, 4'd12, 8'd255, 8'd255, 8'd0);
    send_item(npc_pkg::KIND_QUERY, 4'd6, 8'd1, 8'd254, 8'd127);
    send_item(npc_pkg::KIND_LOAD, 4'd7, 8'd128, 8'd127, 8'd1);
    send_item(npc_pkg::KIND_QUERY, 4'd1, 8'd129, 8'd126, 8'd0);
    wait_drained();

    // all-white palette against a black query: nothing qualifies
    fill_and_query(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    fill_and_query(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      if (n == 120) hold_request = 1'b1;
      if (n == 300) wait_drained();
      if ($urandom_range(0, 99) < 2)
        fill_and_query(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else
        random_item();
    end
    steady = 1'b0;

    wait_drained();
    repeat (CHAIN_LATENCY + 10) @(posedge clk);
    if (pred.fault_count == 0 && pred.pending() == 0)
      $display("nearest_palette_color_core test passed");
    else
      $display("nearest_palette_color_core test failed");
    $finish;
  end

endmodule

>>> nearest_palette_color_core.f
hdl/npc_pkg.sv
hdl/npc_cell.sv
hdl/nearest_palette_color_core.sv
test/nearest_palette_color_core_tb.sv
